@@ hw/rtl/swtm_pkg.sv @@
// Shared types and constants of the sliding window throughput meter.
`default_nettype none

package swtm_pkg;

    localparam int MAX_RESULTS = 16;
    localparam int CFG_IDX_W   = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_PACKETS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_LENGTH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RESEND_TO     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CLEAN_DELAY   = 3'd4;

    localparam logic [15:0] RST_TOTAL_PACKETS = 16'd1000;
    localparam logic [15:0] RST_WINDOW_SIZE   = 16'd1005;
    localparam logic [15:0] RST_FULL_LENGTH   = 16'd1000;
    localparam logic [15:0] RST_RESEND_TO     = 16'd400;
    localparam logic [15:0] RST_CLEAN_DELAY   = 16'd2000;

    typedef enum logic [1:0] {
        MODE_START,
        MODE_ACK,
        MODE_DATA,
        MODE_TICK
    } t_mode;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_SEND_DATA,
        ACT_SEND_ACK,
        ACT_REJECT,
        ACT_DONE
    } t_action;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

    typedef struct packed {
        logic [15:0] sum;
        logic        borrow;
        logic        neg;
        logic        zero;
    } t_alu_res;

    typedef struct packed {
        t_mode       mode;
        logic [47:0] peer_address;
        logic [15:0] seqno;
        logic [15:0] packet_length;
    } t_item;

    typedef struct packed {
        logic [15:0] total_packets;
        logic [15:0] window_size;
        logic [15:0] full_length;
        logic [15:0] resend_timeout_ticks;
        logic [15:0] clean_delay_ticks;
    } t_cfg;

    typedef struct packed {
        t_action     action;
        logic [15:0] seqno;
        logic [15:0] length;
        logic [47:0] peer;
        logic [31:0] elapsed;
        logic        last;
    } t_res;

endpackage

`default_nettype wire

@@ hw/rtl/swtm_alu.sv @@
// Shared 16-bit add/subtract unit with compare flags.
`default_nettype none

module swtm_alu (
    input  var swtm_pkg::t_alu_op  i_op,
    input  wire logic [15:0]       i_a,
    input  wire logic [15:0]       i_b,
    output var swtm_pkg::t_alu_res o_res
);

    logic        w_sub;
    logic [16:0] w_full;

    assign w_sub  = (i_op == swtm_pkg::ALU_SUB);
    assign w_full = {1'b0, i_a} + {1'b0, (w_sub ? ~i_b : i_b)} + {16'd0, w_sub};

    always_comb begin
        o_res.sum    = w_full[15:0];
        o_res.borrow = w_sub ? !w_full[16] : w_full[16];
        o_res.neg    = w_full[15];
        o_res.zero   = (w_full[15:0] == 16'd0);
    end

endmodule

`default_nettype wire

@@ hw/rtl/swtm_seq.sv @@
// Session sequencer: steps one request through the shared arithmetic unit.
`default_nettype none

module swtm_seq #(
    parameter int BURST_LIMIT = 16
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_item_valid,
    input  var swtm_pkg::t_item  i_item,
    output logic                 o_ready,
    input  var swtm_pkg::t_cfg   i_cfg,
    output logic                 o_res_valid,
    output var swtm_pkg::t_res   o_res,
    input  wire logic            i_res_ready
);

    localparam int EFF    = (BURST_LIMIT < swtm_pkg::MAX_RESULTS) ? BURST_LIMIT
                                                                  : swtm_pkg::MAX_RESULTS;
    localparam int SENT_W = $clog2(EFF + 1);

    typedef enum logic [1:0] {
        ROLE_IDLE,
        ROLE_SENDER,
        ROLE_RECEIVER
    } t_role;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_ACK_LO,
        S_ACK_WEND,
        S_ACK_HI,
        S_ACK_SLIDE,
        S_RX_EQ,
        S_RX_INC,
        S_RX_LEN,
        S_T_IDLE,
        S_T_FIN,
        S_T_TO,
        S_CD,
        S_WEND,
        S_LIM,
        S_COND,
        S_INC,
        S_LEN,
        S_DEC,
        S_NEXT,
        S_EMIT
    } t_state;

    t_state                r_state, n_state, r_after, n_after;
    t_role                 r_role, n_role;
    swtm_pkg::t_item       r_item, n_item;
    swtm_pkg::t_res        r_res, n_res;
    logic [47:0]           r_peer, n_peer;
    logic [15:0]           r_ws, n_ws;
    logic [15:0]           r_ns, n_ns;
    logic [15:0]           r_idle, n_idle;
    logic [31:0]           r_test, n_test;
    logic [15:0]           r_cd, n_cd;
    logic                  r_armed, n_armed;
    logic [15:0]           r_lim, n_lim;
    logic [15:0]           r_cur, n_cur;
    logic [15:0]           r_len, n_len;
    logic                  r_lenlast, n_lenlast;
    logic [SENT_W-1:0]     r_sent, n_sent;

    swtm_pkg::t_alu_op     w_op;
    logic [15:0]           w_a;
    logic [15:0]           w_b;
    swtm_pkg::t_alu_res    w_alu;
    logic                  w_more;

    swtm_alu u_alu (
        .i_op  (w_op),
        .i_a   (w_a),
        .i_b   (w_b),
        .o_res (w_alu)
    );

    assign o_ready     = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_EMIT);
    assign o_res       = r_res;
    assign w_more      = w_alu.neg && (r_sent != SENT_W'(EFF - 1));

    always_comb begin
        w_op = swtm_pkg::ALU_SUB;
        w_a  = 16'd0;
        w_b  = 16'd0;
        case (r_state)
            S_ACK_LO: begin
                w_a = r_item.seqno;
                w_b = r_ws;
            end
            S_ACK_WEND, S_WEND: begin
                w_op = swtm_pkg::ALU_ADD;
                w_a  = r_ws;
                w_b  = i_cfg.window_size;
            end
            S_ACK_HI: begin
                w_a = r_item.seqno;
                w_b = r_lim;
            end
            S_ACK_SLIDE: begin
                w_op = swtm_pkg::ALU_ADD;
                w_a  = r_item.seqno;
                w_b  = 16'd1;
            end
            S_RX_EQ: begin
                w_a = r_item.seqno;
                w_b = r_ws;
            end
            S_RX_INC: begin
                w_op = swtm_pkg::ALU_ADD;
                w_a  = r_ws;
                w_b  = 16'd1;
            end
            S_RX_LEN: begin
                w_a = r_item.packet_length;
                w_b = i_cfg.full_length;
            end
            S_T_IDLE: begin
                w_op = swtm_pkg::ALU_ADD;
                w_a  = r_idle;
                w_b  = 16'd1;
            end
            S_T_FIN: begin
                w_a = r_ws;
                w_b = i_cfg.total_packets;
            end
            S_T_TO: begin
                w_a = i_cfg.resend_timeout_ticks;
                w_b = r_idle;
            end
            S_CD: begin
                w_a = r_cd;
                w_b = 16'd1;
            end
            S_LIM: begin
                w_a = r_lim;
                w_b = i_cfg.total_packets;
            end
            S_COND, S_NEXT: begin
                w_a = r_ns;
                w_b = r_lim;
            end
            S_INC: begin
                w_op = swtm_pkg::ALU_ADD;
                w_a  = r_ns;
                w_b  = 16'd1;
            end
            S_LEN: begin
                w_a = r_ns;
                w_b = i_cfg.total_packets;
            end
            S_DEC: begin
                w_a = i_cfg.full_length;
                w_b = 16'd1;
            end
            default: begin
                w_op = swtm_pkg::ALU_SUB;
            end
        endcase
    end

    always_comb begin
        n_state   = r_state;
        n_after   = r_after;
        n_role    = r_role;
        n_item    = r_item;
        n_res     = r_res;
        n_peer    = r_peer;
        n_ws      = r_ws;
        n_ns      = r_ns;
        n_idle    = r_idle;
        n_test    = r_test;
        n_cd      = r_cd;
        n_armed   = r_armed;
        n_lim     = r_lim;
        n_cur     = r_cur;
        n_len     = r_len;
        n_lenlast = r_lenlast;
        n_sent    = r_sent;
        case (r_state)
            S_IDLE: begin
                if (i_item_valid) begin
                    n_item  = i_item;
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_state = S_IDLE;
                case (r_item.mode)
                    swtm_pkg::MODE_START: begin
                        if (r_role != ROLE_IDLE) begin
                            n_res   = '{swtm_pkg::ACT_REJECT, 16'd0, 16'd0, 48'd0, 32'd0, 1'b1};
                            n_after = S_IDLE;
                            n_state = S_EMIT;
                        end else begin
                            n_role  = ROLE_SENDER;
                            n_peer  = r_item.peer_address;
                            n_ws    = 16'd0;
                            n_ns    = 16'd0;
                            n_idle  = 16'd0;
                            n_test  = 32'd0;
                            n_armed = 1'b0;
                            n_cd    = 16'd0;
                            n_sent  = '0;
                            n_state = S_WEND;
                        end
                    end
                    swtm_pkg::MODE_ACK: begin
                        if (r_role == ROLE_SENDER && r_item.peer_address == r_peer) begin
                            n_state = S_ACK_LO;
                        end
                    end
                    swtm_pkg::MODE_DATA: begin
                        if (r_role == ROLE_IDLE) begin
                            if (r_item.seqno == 16'd0) begin
                                n_role  = ROLE_RECEIVER;
                                n_peer  = r_item.peer_address;
                                n_ws    = 16'd0;
                                n_armed = 1'b0;
                                n_cd    = 16'd0;
                                n_state = S_RX_EQ;
                            end
                        end else if (r_role != ROLE_RECEIVER ||
                                     r_item.peer_address != r_peer) begin
                            n_res   = '{swtm_pkg::ACT_REJECT, 16'd0, 16'd0, 48'd0, 32'd0, 1'b1};
                            n_after = S_IDLE;
                            n_state = S_EMIT;
                        end else begin
                            n_state = S_RX_EQ;
                        end
                    end
                    swtm_pkg::MODE_TICK: begin
                        if (r_role == ROLE_SENDER) begin
                            n_test  = r_test + 32'd1;
                            n_state = S_T_IDLE;
                        end else if (r_role == ROLE_RECEIVER && r_armed) begin
                            n_state = S_CD;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_ACK_LO: begin
                n_state = w_alu.neg ? S_IDLE : S_ACK_WEND;
            end
            S_ACK_WEND: begin
                n_lim   = w_alu.sum;
                n_state = S_ACK_HI;
            end
            S_ACK_HI: begin
                n_state = w_alu.neg ? S_ACK_SLIDE : S_IDLE;
            end
            S_ACK_SLIDE: begin
                n_ws    = w_alu.sum;
                n_sent  = '0;
                n_state = S_WEND;
            end
            S_RX_EQ: begin
                n_state = w_alu.zero ? S_RX_INC : S_IDLE;
            end
            S_RX_INC: begin
                n_ws    = w_alu.sum;
                n_state = S_RX_LEN;
            end
            S_RX_LEN: begin
                if (w_alu.borrow && !r_armed) begin
                    n_armed = 1'b1;
                    n_cd    = i_cfg.clean_delay_ticks;
                end
                n_res   = '{swtm_pkg::ACT_SEND_ACK, r_item.seqno, 16'd0, r_peer, 32'd0, 1'b1};
                n_after = S_IDLE;
                n_state = S_EMIT;
            end
            S_T_IDLE: begin
                if (r_idle != 16'hFFFF) begin
                    n_idle = w_alu.sum;
                end
                n_state = S_T_FIN;
            end
            S_T_FIN: begin
                if (!w_alu.neg) begin
                    n_role  = ROLE_IDLE;
                    n_res   = '{swtm_pkg::ACT_DONE, 16'd0, 16'd0, r_peer, r_test, 1'b1};
                    n_after = S_IDLE;
                    n_state = S_EMIT;
                end else begin
                    n_state = S_T_TO;
                end
            end
            S_T_TO: begin
                if (w_alu.borrow) begin
                    n_ns    = r_ws;
                    n_sent  = '0;
                    n_state = S_WEND;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_CD: begin
                if (w_alu.borrow || w_alu.zero) begin
                    n_cd    = 16'd0;
                    n_armed = 1'b0;
                    n_role  = ROLE_IDLE;
                end else begin
                    n_cd = w_alu.sum;
                end
                n_state = S_IDLE;
            end
            S_WEND: begin
                n_lim   = w_alu.sum;
                n_state = S_LIM;
            end
            S_LIM: begin
                if (!w_alu.borrow) begin
                    n_lim = i_cfg.total_packets;
                end
                n_state = S_COND;
            end
            S_COND: begin
                n_state = w_alu.neg ? S_INC : S_IDLE;
            end
            S_INC: begin
                n_cur   = r_ns;
                n_ns    = w_alu.sum;
                n_idle  = 16'd0;
                n_state = S_LEN;
            end
            S_LEN: begin
                n_lenlast = w_alu.zero;
                n_state   = S_DEC;
            end
            S_DEC: begin
                n_len   = r_lenlast ? w_alu.sum : i_cfg.full_length;
                n_state = S_NEXT;
            end
            S_NEXT: begin
                n_res   = '{swtm_pkg::ACT_SEND_DATA, r_cur, r_len, r_peer, 32'd0, !w_more};
                n_after = w_more ? S_INC : S_IDLE;
                if (w_more) begin
                    n_sent = r_sent + SENT_W'(1);
                end
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_res_ready) begin
                    n_state = r_after;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_after <= S_IDLE;
            r_role  <= ROLE_IDLE;
            r_peer  <= 48'd0;
            r_ws    <= 16'd0;
            r_ns    <= 16'd0;
            r_idle  <= 16'd0;
            r_test  <= 32'd0;
            r_cd    <= 16'd0;
            r_armed <= 1'b0;
            r_sent  <= '0;
        end else begin
            r_state <= n_state;
            r_after <= n_after;
            r_role  <= n_role;
            r_peer  <= n_peer;
            r_ws    <= n_ws;
            r_ns    <= n_ns;
            r_idle  <= n_idle;
            r_test  <= n_test;
            r_cd    <= n_cd;
            r_armed <= n_armed;
            r_sent  <= n_sent;
        end
        r_item    <= n_item;
        r_res     <= n_res;
        r_lim     <= n_lim;
        r_cur     <= n_cur;
        r_len     <= n_len;
        r_lenlast <= n_lenlast;
    end

endmodule

`default_nettype wire

@@ hw/rtl/sliding_window_throughput_meter.sv @@
// Top level of the sliding window throughput meter: config registers and output stage.
//
// Runs one go-back-N test session with one peer, as sender (opened by a start
// request) or receiver (opened by a data packet with sequence 0).
// Input stream: tuser carries the mode (start, ack, data, tick), tdata the
// peer address, sequence number and packet length. One request is taken at a
// time; s_axis_tready stays low until all its results are in the output register.
// Output stream: tuser carries the action, tlast marks the final result of a
// request, tdata the sequence, length, peer and elapsed ticks.
// A reject, a receiver ack and a tick without a resend give at most one result;
// a start, an ack and a resend tick compute the window before a burst, and every
// data packet of a burst passes through the shared 16-bit add/subtract unit. A
// burst holds at most min(BURST_LIMIT, 16) packets. Requests may give no result.
// A result waits in one output register; while the receiver stalls, the
// sequencer holds the next result and stops.
// Reset (synchronous, active low) closes any session and restores the
// register defaults. Write configuration only while no request is in flight.
`default_nettype none

module sliding_window_throughput_meter #(
    parameter int BURST_LIMIT = 16
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [79:0]  s_axis_tdata,   // peer_address, seqno, packet_length
    input  wire logic [1:0]   s_axis_tuser,   // mode
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [111:0]      m_axis_tdata,   // out_seqno, out_length, out_peer, elapsed_ticks
    output logic [2:0]        m_axis_tuser,   // action
    output logic              m_axis_tlast,
    input  wire logic         i_cfg_wr_en,
    input  wire logic [swtm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [15:0]  i_cfg_wr_data
);

    swtm_pkg::t_cfg  r_cfg;
    swtm_pkg::t_item w_item;
    swtm_pkg::t_res  w_res;
    swtm_pkg::t_res  r_out;
    logic            r_out_valid;
    logic            w_res_valid;
    logic            w_res_ready;
    logic            w_take;

    assign w_item.mode          = swtm_pkg::t_mode'(s_axis_tuser);
    assign w_item.peer_address  = s_axis_tdata[47:0];
    assign w_item.seqno         = s_axis_tdata[63:48];
    assign w_item.packet_length = s_axis_tdata[79:64];

    swtm_seq #(
        .BURST_LIMIT (BURST_LIMIT)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (s_axis_tvalid),
        .i_item       (w_item),
        .o_ready      (s_axis_tready),
        .i_cfg        (r_cfg),
        .o_res_valid  (w_res_valid),
        .o_res        (w_res),
        .i_res_ready  (w_res_ready)
    );

    assign w_res_ready = !r_out_valid || m_axis_tready;
    assign w_take      = w_res_valid && w_res_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.total_packets        <= swtm_pkg::RST_TOTAL_PACKETS;
            r_cfg.window_size          <= swtm_pkg::RST_WINDOW_SIZE;
            r_cfg.full_length          <= swtm_pkg::RST_FULL_LENGTH;
            r_cfg.resend_timeout_ticks <= swtm_pkg::RST_RESEND_TO;
            r_cfg.clean_delay_ticks    <= swtm_pkg::RST_CLEAN_DELAY;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                swtm_pkg::CFG_TOTAL_PACKETS: r_cfg.total_packets        <= i_cfg_wr_data;
                swtm_pkg::CFG_WINDOW_SIZE:   r_cfg.window_size          <= i_cfg_wr_data;
                swtm_pkg::CFG_FULL_LENGTH:   r_cfg.full_length          <= i_cfg_wr_data;
                swtm_pkg::CFG_RESEND_TO:     r_cfg.resend_timeout_ticks <= i_cfg_wr_data;
                swtm_pkg::CFG_CLEAN_DELAY:   r_cfg.clean_delay_ticks    <= i_cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (w_take) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out.elapsed, r_out.peer, r_out.length, r_out.seqno};
    assign m_axis_tuser  = r_out.action;
    assign m_axis_tlast  = r_out.last;

    a_no_accept_while_emitting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !w_res_valid)
        else $error("input ready while a result is pending");

    a_one_request_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("ready held after accepting a request");

    a_action_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (m_axis_tuser != swtm_pkg::ACT_NONE) &&
                        (m_axis_tuser <= swtm_pkg::ACT_DONE))
        else $error("result with no action");

    a_single_results_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (m_axis_tuser != swtm_pkg::ACT_SEND_DATA) |-> m_axis_tlast)
        else $error("ack, reject or done without last");

endmodule

`default_nettype wire

@@ test/tb_sliding_window_throughput_meter.sv @@
// Testbench for the sliding window throughput meter: predicts each request's results and checks them.
`default_nettype none

module tb_sliding_window_throughput_meter;
    import swtm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int BURST_LIMIT = 16;
    localparam int SETTLE_CYCLES = 24;
    localparam int CYCLE_LIMIT = 2000000;
    localparam logic [47:0] PEER_A = 48'h0000_0000_0000;
    localparam logic [47:0] PEER_B = 48'hFFFF_FFFF_FFFF;
    localparam logic [47:0] PEER_C = 48'h5A5A_0F0F_3C3C;

    typedef enum logic [1:0] {
        SESS_IDLE,
        SESS_SENDER,
        SESS_RECEIVER
    } t_sess_role;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic [79:0] s_tdata = '0;
    logic [1:0] s_tuser = '0;
    logic m_tready = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;

    wire logic s_ready;
    wire logic m_valid;
    wire logic [111:0] m_data;
    wire logic [2:0] m_user;
    wire logic m_last;

    sliding_window_throughput_meter #(
        .BURST_LIMIT(BURST_LIMIT)
    ) uut (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .s_axis_tvalid(s_tvalid),
        .s_axis_tready(s_ready),
        .s_axis_tdata(s_tdata),
        .s_axis_tuser(s_tuser),
        .m_axis_tvalid(m_valid),
        .m_axis_tready(m_tready),
        .m_axis_tdata(m_data),
        .m_axis_tuser(m_user),
        .m_axis_tlast(m_last),
        .i_cfg_wr_en(cfg_wr_en),
        .i_cfg_index(cfg_index),
        .i_cfg_wr_data(cfg_data)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    logic [15:0] cfg_total, cfg_window, cfg_full, cfg_resend, cfg_linger;
    t_sess_role sess_role;
    logic [47:0] sess_peer;
    logic [15:0] win_base, next_seq, quiet_ticks, linger_cnt;
    logic [31:0] run_ticks;
    bit linger_on;

    t_res item_results[$];
    t_res results_due[$];

    int mismatches = 0;
    int cycles = 0;
    int rx_stall = 0;
    bit tx_steady = 1'b0;
    bit rx_steady = 1'b0;

    function automatic bit seq_before(logic [15:0] a, logic [15:0] b);
        logic [15:0] d;
        d = a - b;
        return d[15];
    endfunction

    function automatic void queue_result(t_action act, logic [15:0] sq, logic [15:0] ln,
                                         logic [47:0] to, logic [31:0] el);
        t_res r;
        r.action = act;
        r.seqno = sq;
        r.length = ln;
        r.peer = to;
        r.elapsed = el;
        r.last = 1'b0;
        item_results.push_back(r);
    endfunction

    task automatic reset_session_model();
        cfg_total = RST_TOTAL_PACKETS;
        cfg_window = RST_WINDOW_SIZE;
        cfg_full = RST_FULL_LENGTH;
        cfg_resend = RST_RESEND_TO;
        cfg_linger = RST_CLEAN_DELAY;
        sess_role = SESS_IDLE;
        sess_peer = '0;
        win_base = '0;
        next_seq = '0;
        quiet_ticks = '0;
        run_ticks = '0;
        linger_cnt = '0;
        linger_on = 1'b0;
    endtask

    task automatic fill_window();
        int sent;
        logic [15:0] wend, lim, len, sq;
        sent = 0;
        while (sent < BURST_LIMIT && item_results.size() < MAX_RESULTS) begin
            wend = win_base + cfg_window;
            lim = (wend < cfg_total) ? wend : cfg_total;
            if (!seq_before(next_seq, lim)) break;
            sq = next_seq;
            next_seq = next_seq + 16'd1;
            len = (next_seq == cfg_total) ? cfg_full - 16'd1 : cfg_full;
            queue_result(ACT_SEND_DATA, sq, len, sess_peer, 32'd0);
            quiet_ticks = '0;
            sent++;
        end
    endtask

    task automatic step_session(input t_mode m, input logic [47:0] addr, input logic [15:0] seq,
                                input logic [15:0] plen);
        logic [15:0] wend;
        item_results.delete();
        case (m)
            MODE_START: begin
                if (sess_role != SESS_IDLE) begin
                    queue_result(ACT_REJECT, 16'd0, 16'd0, 48'd0, 32'd0);
                end else begin
                    sess_role = SESS_SENDER;
                    sess_peer = addr;
                    win_base = '0;
                    next_seq = '0;
                    quiet_ticks = '0;
                    run_ticks = '0;
                    linger_on = 1'b0;
                    linger_cnt = '0;
                    fill_window();
                end
            end
            MODE_ACK: begin
                if (sess_role == SESS_SENDER && addr == sess_peer) begin
                    wend = win_base + cfg_window;
                    if (!seq_before(seq, win_base) && seq_before(seq, wend)) begin
                        win_base = seq + 16'd1;
                        fill_window();
                    end
                end
            end
            MODE_DATA: begin
                if (sess_role == SESS_IDLE) begin
                    if (seq == 16'd0) begin
                        sess_role = SESS_RECEIVER;
                        sess_peer = addr;
                        win_base = '0;
                        linger_on = 1'b0;
                        linger_cnt = '0;
                    end
                end else if (sess_role != SESS_RECEIVER || addr != sess_peer) begin
                    queue_result(ACT_REJECT, 16'd0, 16'd0, 48'd0, 32'd0);
                end
                if (sess_role == SESS_RECEIVER && addr == sess_peer && item_results.size() == 0
                        && seq == win_base) begin
                    win_base = win_base + 16'd1;
                    queue_result(ACT_SEND_ACK, seq, 16'd0, sess_peer, 32'd0);
                    if (plen < cfg_full && !linger_on) begin
                        linger_on = 1'b1;
                        linger_cnt = cfg_linger;
                    end
                end
            end
            default: begin
                if (sess_role == SESS_SENDER) begin
                    run_ticks = run_ticks + 32'd1;
                    if (quiet_ticks != 16'hFFFF) quiet_ticks = quiet_ticks + 16'd1;
                    if (!seq_before(win_base, cfg_total)) begin
                        queue_result(ACT_DONE, 16'd0, 16'd0, sess_peer, run_ticks);
                        sess_role = SESS_IDLE;
                    end else if (quiet_ticks > cfg_resend) begin
                        next_seq = win_base;
                        fill_window();
                    end
                end else if (sess_role == SESS_RECEIVER && linger_on) begin
                    if (linger_cnt <= 16'd1) begin
                        linger_cnt = '0;
                        linger_on = 1'b0;
                        sess_role = SESS_IDLE;
                    end else begin
                        linger_cnt = linger_cnt - 16'd1;
                    end
                end
            end
        endcase
        if (item_results.size() > 0) item_results[$].last = 1'b1;
        foreach (item_results[i]) results_due.push_back(item_results[i]);
    endtask

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (tx_steady || r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 50);
    endfunction

    function automatic int stall_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 2);
        if (r < 95) return $urandom_range(3, 8);
        return $urandom_range(15, 40);
    endfunction

    function automatic logic [47:0] rand_addr();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[47:0];
    endfunction

    function automatic logic [47:0] other_addr(logic [47:0] a);
        return a ^ (48'd1 << $urandom_range(0, 47));
    endfunction

    task automatic send_request(input t_mode m, input logic [47:0] addr, input logic [15:0] seq,
                                input logic [15:0] plen);
        int gap;
        gap = gap_length();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= m;
        s_tdata <= {plen, seq, addr};
        @(posedge clk);
        while (!s_ready) @(posedge clk);
        step_session(m, addr, seq, plen);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (results_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            CFG_TOTAL_PACKETS: cfg_total = val;
            CFG_WINDOW_SIZE:   cfg_window = val;
            CFG_FULL_LENGTH:   cfg_full = val;
            CFG_RESEND_TO:     cfg_resend = val;
            CFG_CLEAN_DELAY:   cfg_linger = val;
            default: ;
        endcase
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic close_session();
        drain();
        if (sess_role == SESS_SENDER) begin
            write_reg(CFG_TOTAL_PACKETS, (win_base == 16'd0) ? 16'h8001 : win_base);
            send_request(MODE_TICK, rand_addr(), 16'($urandom), 16'($urandom));
        end else if (sess_role == SESS_RECEIVER) begin
            if (!linger_on) begin
                write_reg(CFG_CLEAN_DELAY, 16'($urandom_range(1, 3)));
                send_request(MODE_DATA, sess_peer, win_base, 16'd0);
            end
            while (sess_role != SESS_IDLE)
                send_request(MODE_TICK, rand_addr(), 16'($urandom), 16'($urandom));
        end
        drain();
    endtask

    task automatic test_directed();
        send_request(MODE_TICK, PEER_B, 16'hFFFF, 16'hFFFF);
        send_request(MODE_ACK, PEER_B, 16'h0000, 16'h0000);
        send_request(MODE_DATA, PEER_B, 16'hFFFF, 16'hFFFF);
        send_request(MODE_START, PEER_A, 16'h0000, 16'h0000);
        send_request(MODE_START, PEER_B, 16'h0000, 16'h0000);
        send_request(MODE_ACK, PEER_B, 16'd3, 16'd0);
        send_request(MODE_ACK, PEER_A, 16'hFFFF, 16'd0);
        send_request(MODE_ACK, PEER_A, 16'd3, 16'd0);
        send_request(MODE_ACK, PEER_A, 16'd1, 16'd0);
        send_request(MODE_DATA, PEER_A, 16'd4, 16'd1000);
        close_session();

        write_reg(CFG_CLEAN_DELAY, 16'd2);
        send_request(MODE_DATA, PEER_B, 16'd0, 16'hFFFF);
        send_request(MODE_DATA, PEER_B, 16'd5, 16'd1000);
        send_request(MODE_DATA, PEER_C, 16'd1, 16'd1000);
        send_request(MODE_START, PEER_C, 16'd0, 16'd0);
        send_request(MODE_DATA, PEER_B, 16'd1, 16'd0);
        send_request(MODE_TICK, PEER_A, 16'd0, 16'd0);
        send_request(MODE_DATA, PEER_B, 16'd2, 16'd0);
        send_request(MODE_TICK, PEER_A, 16'd0, 16'd0);
        drain();

        write_reg(CFG_TOTAL_PACKETS, 16'd0);
        write_reg(CFG_FULL_LENGTH, 16'd0);
        send_request(MODE_START, PEER_C, 16'd0, 16'd0);
        send_request(MODE_TICK, PEER_C, 16'd0, 16'd0);
        drain();
        write_reg(CFG_TOTAL_PACKETS, 16'd1);
        send_request(MODE_START, PEER_C, 16'd0, 16'd0);
        send_request(MODE_ACK, PEER_C, 16'd0, 16'd0);
        send_request(MODE_TICK, PEER_C, 16'd0, 16'd0);
        drain();
        write_reg(CFG_TOTAL_PACKETS, RST_TOTAL_PACKETS);
        write_reg(CFG_FULL_LENGTH, RST_FULL_LENGTH);
        write_reg(CFG_CLEAN_DELAY, RST_CLEAN_DELAY);
    endtask

    task automatic test_register_extremes();
        drain();
        write_reg(CFG_TOTAL_PACKETS, 16'hFFFF);
        write_reg(CFG_WINDOW_SIZE, 16'hFFFF);
        write_reg(CFG_FULL_LENGTH, 16'hFFFF);
        write_reg(CFG_RESEND_TO, 16'hFFFF);
        write_reg(CFG_CLEAN_DELAY, 16'hFFFF);
        send_request(MODE_START, PEER_C, 16'd0, 16'd0);
        send_request(MODE_ACK, PEER_C, 16'd32767, 16'd0);
        repeat (3) send_request(MODE_TICK, PEER_C, 16'($urandom), 16'($urandom));
        close_session();
        send_request(MODE_DATA, PEER_B, 16'd0, 16'hFFFF);
        send_request(MODE_DATA, PEER_B, 16'd1, 16'hFFFF);
        close_session();

        write_reg(CFG_TOTAL_PACKETS, 16'd1);
        write_reg(CFG_WINDOW_SIZE, 16'd1);
        write_reg(CFG_FULL_LENGTH, 16'd2);
        write_reg(CFG_RESEND_TO, 16'd1);
        write_reg(CFG_CLEAN_DELAY, 16'd1);
        send_request(MODE_START, PEER_B, 16'd0, 16'd0);
        send_request(MODE_TICK, PEER_B, 16'd0, 16'd0);
        send_request(MODE_TICK, PEER_B, 16'd0, 16'd0);
        send_request(MODE_ACK, PEER_B, 16'd0, 16'd0);
        send_request(MODE_TICK, PEER_B, 16'd0, 16'd0);
        send_request(MODE_DATA, PEER_A, 16'd0, 16'd1);
        send_request(MODE_TICK, PEER_A, 16'd0, 16'd0);
        drain();
    endtask

    task automatic test_sender_sessions();
        int budget, steps, pick;
        logic [15:0] span, off;
        budget = 0;
        while (budget < 130) begin
            drain();
            tx_steady = ($urandom_range(0, 4) == 0);
            rx_steady = ($urandom_range(0, 4) == 0);
            write_reg(CFG_TOTAL_PACKETS, 16'(($urandom_range(0, 4) != 0) ?
                      $urandom_range(1, 40) : $urandom_range(41, 300)));
            write_reg(CFG_WINDOW_SIZE, 16'(($urandom_range(0, 4) != 0) ?
                      $urandom_range(1, 20) : $urandom_range(21, 2000)));
            write_reg(CFG_FULL_LENGTH, 16'($urandom_range(2, 65535)));
            write_reg(CFG_RESEND_TO, 16'($urandom_range(1, 6)));
            send_request(MODE_START, rand_addr(), 16'($urandom), 16'($urandom));
            budget++;
            steps = 0;
            while (sess_role == SESS_SENDER && steps < 60) begin
                pick = $urandom_range(0, 99);
                span = next_seq - win_base;
                off = 16'($urandom_range(0, span));
                if (pick < 45) begin
                    send_request(MODE_ACK, sess_peer, win_base + off, 16'($urandom));
                end else if (pick < 80) begin
                    send_request(MODE_TICK, rand_addr(), 16'($urandom), 16'($urandom));
                end else if (pick < 85) begin
                    send_request(MODE_ACK, sess_peer, ($urandom_range(0, 1) == 0) ?
                                 win_base - 16'($urandom_range(1, 5)) : 16'($urandom),
                                 16'($urandom));
                end else if (pick < 90) begin
                    send_request(MODE_ACK, other_addr(sess_peer), win_base + off,
                                 16'($urandom));
                end else if (pick < 94) begin
                    send_request(MODE_DATA, ($urandom_range(0, 1) == 0) ? sess_peer : rand_addr(),
                                 16'($urandom), 16'($urandom));
                end else if (pick < 97) begin
                    send_request(MODE_START, rand_addr(), 16'($urandom), 16'($urandom));
                end else begin
                    drain();
                    continue;
                end
                steps++;
                budget++;
            end
            close_session();
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    task automatic test_receiver_sessions();
        int budget, steps, pick, npk;
        logic [15:0] sq, ln;
        budget = 0;
        while (budget < 85) begin
            drain();
            tx_steady = ($urandom_range(0, 4) == 0);
            rx_steady = ($urandom_range(0, 4) == 0);
            write_reg(CFG_FULL_LENGTH, 16'(($urandom_range(0, 9) < 7) ?
                      $urandom_range(2, 1500) : $urandom_range(2, 65535)));
            write_reg(CFG_CLEAN_DELAY, 16'($urandom_range(1, 6)));
            send_request(MODE_DATA, rand_addr(), 16'd0, 16'($urandom_range(cfg_full, 65535)));
            budget++;
            npk = $urandom_range(1, 25);
            steps = 0;
            while (sess_role == SESS_RECEIVER && steps < 70) begin
                pick = $urandom_range(0, 99);
                if (pick < 50) begin
                    ln = 16'((win_base >= npk - 1 || $urandom_range(0, 19) == 0) ?
                         $urandom_range(0, cfg_full - 1) : $urandom_range(cfg_full, 65535));
                    send_request(MODE_DATA, sess_peer, win_base, ln);
                end else if (pick < 62) begin
                    case ($urandom_range(0, 2))
                        0: sq = win_base + 16'($urandom_range(1, 4));
                        1: sq = win_base - 16'($urandom_range(1, 3));
                        default: sq = 16'($urandom);
                    endcase
                    send_request(MODE_DATA, sess_peer, sq, 16'($urandom));
                end else if (pick < 70) begin
                    send_request(MODE_DATA, other_addr(sess_peer), win_base, 16'($urandom));
                end else if (pick < 75) begin
                    send_request(MODE_START, rand_addr(), 16'($urandom), 16'($urandom));
                end else if (pick < 80) begin
                    send_request(MODE_ACK, sess_peer, win_base, 16'($urandom));
                end else begin
                    send_request(MODE_TICK, rand_addr(), 16'($urandom), 16'($urandom));
                end
                steps++;
                budget++;
            end
            close_session();
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    task automatic test_mixed_noise();
        logic [47:0] addr, home;
        logic [15:0] sq;
        int r;
        repeat (4) begin
            drain();
            home = rand_addr();
            write_reg(CFG_TOTAL_PACKETS, 16'($urandom_range(1, 65535)));
            write_reg(CFG_WINDOW_SIZE, 16'($urandom_range(1, 65535)));
            write_reg(CFG_FULL_LENGTH, 16'($urandom_range(2, 65535)));
            write_reg(CFG_RESEND_TO, 16'($urandom_range(1, 8)));
            write_reg(CFG_CLEAN_DELAY, 16'($urandom_range(1, 8)));
            repeat (15) begin
                r = $urandom_range(0, 99);
                addr = (r < 40) ? home : (r < 70) ? sess_peer : rand_addr();
                r = $urandom_range(0, 99);
                sq = (r < 30) ? 16'd0 : (r < 60) ? win_base + 16'($urandom_range(0, 3)) :
                     16'($urandom);
                send_request(t_mode'($urandom_range(0, 3)), addr, sq, 16'($urandom));
            end
            close_session();
        end
    endtask

    always @(posedge clk) begin
        if (rx_stall > 0) begin
            rx_stall--;
            m_tready <= 1'b0;
        end else if (!rx_steady && $urandom_range(0, 99) < 25) begin
            rx_stall = stall_length() - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    function automatic void check_field(string name, logic [47:0] want, logic [47:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk) begin : check_results
        t_res want;
        if (rst_n && m_valid && m_tready) begin
            if (results_due.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual action %0d seqno %0h",
                         $time, m_user, m_data[15:0]);
                mismatches++;
            end else begin
                want = results_due.pop_front();
                check_field("action", 48'(want.action), 48'(m_user));
                check_field("seqno", 48'(want.seqno), 48'(m_data[15:0]));
                check_field("length", 48'(want.length), 48'(m_data[31:16]));
                check_field("peer", want.peer, m_data[79:32]);
                check_field("elapsed", 48'(want.elapsed), 48'(m_data[111:80]));
                check_field("last", 48'(want.last), 48'(m_last));
            end
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("sliding_window_throughput_meter test failed");
            $finish;
        end
    end

    initial begin
        reset_session_model();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_register_extremes();
        test_sender_sessions();
        test_receiver_sessions();
        test_mixed_noise();
        drain();
        if (mismatches == 0 && results_due.size() == 0) begin
            $display("sliding_window_throughput_meter test passed");
        end else begin
            $display("sliding_window_throughput_meter test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
